// ===== src/mckt_pkg.sv =====
// ============================================================================
// mckt_pkg : shared types and constants for the MRU-cached key table
// Outcome codes, field widths and the recent-list update command.
// ============================================================================
package mckt_pkg;

    localparam int KEY_W  = 64;
    localparam int IDX_W  = 8;
    localparam int CODE_W = 2;
    localparam int SLOT_W = 4;   // enough for up to 16 recent slots

    // Outcome codes
    localparam logic [CODE_W-1:0] OUT_RECENT_HIT = 2'd0;
    localparam logic [CODE_W-1:0] OUT_TABLE_HIT  = 2'd1;
    localparam logic [CODE_W-1:0] OUT_ALLOCATED  = 2'd2;
    localparam logic [CODE_W-1:0] OUT_FULL       = 2'd3;

    // Update command for the recent list
    typedef struct packed {
        logic              slot_hit;   // swap hit slot with slot 0
        logic              table_hit;  // slot 0 <= idx, others <= old slot 0
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  idx;
    } t_rec_upd;

endpackage

// ===== src/mckt_key_mem.sv =====
// ============================================================================
// mckt_key_mem : key storage for the descriptor table
// One write port, one read port, registered read data.
// ============================================================================
module mckt_key_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [mckt_pkg::KEY_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [mckt_pkg::KEY_W-1:0] o_rd_data
);

    logic [mckt_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [mckt_pkg::KEY_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/mckt_recent.sv =====
// ============================================================================
// mckt_recent : most-recently-used list of table indices
// Holds index and valid per slot; one read slot, swap and spread updates.
// ============================================================================
module mckt_recent #(
    parameter int SLOTS = 5,
    parameter int SW    = $clog2(SLOTS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [SW-1:0]             i_rd_slot,
    output logic [mckt_pkg::IDX_W-1:0] o_rd_idx,
    output logic                      o_rd_val,
    input  mckt_pkg::t_rec_upd        i_upd
);

    logic [mckt_pkg::IDX_W-1:0] r_idx [SLOTS];
    logic                       r_val [SLOTS];
    logic [SW-1:0]              hit_slot;

    assign hit_slot = i_upd.slot[SW-1:0];

    // Slot read
    assign o_rd_idx = r_idx[i_rd_slot];
    assign o_rd_val = r_val[i_rd_slot];

    // List update: swap on a list hit, spread old slot 0 on a table hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_idx[s] <= '0;
                r_val[s] <= 1'b0;
            end
        end else if (i_upd.slot_hit) begin
            // a hit in slot 0 swaps with itself
            if (hit_slot != '0) begin
                r_idx[hit_slot] <= r_idx[0];
                r_val[hit_slot] <= r_val[0];
            end
            r_idx[0]        <= i_upd.idx;
            r_val[0]        <= 1'b1;
        end else if (i_upd.table_hit) begin
            for (int s = 1; s < SLOTS; s++) begin
                r_idx[s] <= r_idx[0];
                r_val[s] <= r_val[0];
            end
            r_idx[0] <= i_upd.idx;
            r_val[0] <= 1'b1;
        end
    end

endmodule

// ===== src/mru_cached_key_table_lookup_alloc_core.sv =====
// ============================================================================
// mru_cached_key_table_lookup_alloc_core : key lookup with MRU list and alloc
// Finds a 64-bit key through a recent list, then the table; else installs it.
// ============================================================================
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | i_in_valid / o_in_ready   | i_format_key
//  output   | o_out_valid / i_out_ready | o_entry_index, o_outcome
//
//  The key is taken in idle, then one key-memory read and compare per cycle
//  over the recent slots and the filled entries, up to the match; a miss adds
//  one allocate step. The key memory has a single read port.
//  Entries fill from index 0 up and are never freed, so a fill count stands
//  for the valid bits; reset (synchronous, active low) needs no clearing pass.
//  A new key is taken while the previous result waits; the last step stalls.
//
module mru_cached_key_table_lookup_alloc_core #(
    parameter int TABLE_ENTRIES = 256,
    parameter int RECENT_SLOTS  = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mckt_pkg::KEY_W-1:0]     i_format_key,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mckt_pkg::IDX_W-1:0]     o_entry_index,
    output logic [mckt_pkg::CODE_W-1:0]    o_outcome
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = (CW > mckt_pkg::IDX_W) ? CW : mckt_pkg::IDX_W;
    localparam int SW = $clog2(RECENT_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RCMP  = 4'b0010,
        S_TCMP  = 4'b0100,
        S_ALLOC = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [mckt_pkg::KEY_W-1:0]     r_key, n_key;
    logic [SW-1:0]                  r_slot, n_slot;
    logic [mckt_pkg::IDX_W-1:0]     r_cur_idx, n_cur_idx;
    logic                           r_cur_ok, n_cur_ok;
    logic [AW-1:0]                  r_tidx, n_tidx;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_out_valid, n_out_valid;
    logic [mckt_pkg::IDX_W-1:0]     r_out_idx, n_out_idx;
    logic [mckt_pkg::CODE_W-1:0]    r_out_code, n_out_code;

    logic                           rd_en, wr_en;
    logic [AW-1:0]                  rd_addr, wr_addr;
    logic [mckt_pkg::KEY_W-1:0]     rd_data;
    logic [SW-1:0]                  rec_rd_slot;
    logic [mckt_pkg::IDX_W-1:0]     rec_rd_idx;
    logic                           rec_rd_val;
    logic [LW-1:0]                  rec_ext, count_ext, tidx_ext;
    logic                           rec_ok, key_match, out_free;
    mckt_pkg::t_rec_upd             rec_upd;

    // Key memory
    mckt_key_mem #(
        .DEPTH (TABLE_ENTRIES)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Recent list
    mckt_recent #(
        .SLOTS (RECENT_SLOTS)
    ) u_recent (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_slot (rec_rd_slot),
        .o_rd_idx  (rec_rd_idx),
        .o_rd_val  (rec_rd_val),
        .i_upd     (rec_upd)
    );

    // Slot to look at next, and whether it names a filled entry
    assign rec_rd_slot = (r_state == S_RCMP) ? SW'(r_slot + 1'b1) : '0;
    assign rec_ext     = LW'(rec_rd_idx);
    assign count_ext   = LW'(r_count);
    assign tidx_ext    = LW'(r_tidx);
    assign rec_ok      = rec_rd_val && (rec_ext < count_ext);
    assign key_match   = (rd_data == r_key);
    assign out_free    = !r_out_valid || i_out_ready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_slot      = r_slot;
        n_cur_idx   = r_cur_idx;
        n_cur_ok    = r_cur_ok;
        n_tidx      = r_tidx;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_idx   = r_out_idx;
        n_out_code  = r_out_code;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        rec_upd     = '0;
        o_in_ready  = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key     = i_format_key;
                    n_slot    = '0;
                    rd_en     = 1'b1;
                    rd_addr   = rec_ext[AW-1:0];
                    n_cur_idx = rec_rd_idx;
                    n_cur_ok  = rec_ok;
                    n_state   = S_RCMP;
                end
            end
            S_RCMP: begin
                if (r_cur_ok && key_match) begin
                    if (out_free) begin
                        rec_upd.slot_hit = 1'b1;
                        rec_upd.slot     = mckt_pkg::SLOT_W'(r_slot);
                        rec_upd.idx      = r_cur_idx;
                        n_out_valid      = 1'b1;
                        n_out_idx        = r_cur_idx;
                        n_out_code       = mckt_pkg::OUT_RECENT_HIT;
                        n_state          = S_IDLE;
                    end
                end else if (r_slot != SW'(RECENT_SLOTS - 1)) begin
                    n_slot    = SW'(r_slot + 1'b1);
                    rd_en     = 1'b1;
                    rd_addr   = rec_ext[AW-1:0];
                    n_cur_idx = rec_rd_idx;
                    n_cur_ok  = rec_ok;
                end else if (r_count != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_tidx  = '0;
                    n_state = S_TCMP;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_TCMP: begin
                if (key_match) begin
                    if (out_free) begin
                        rec_upd.table_hit = 1'b1;
                        rec_upd.idx       = tidx_ext[mckt_pkg::IDX_W-1:0];
                        n_out_valid       = 1'b1;
                        n_out_idx         = tidx_ext[mckt_pkg::IDX_W-1:0];
                        n_out_code        = mckt_pkg::OUT_TABLE_HIT;
                        n_state           = S_IDLE;
                    end
                end else if (CW'(r_tidx) != (r_count - CW'(1))) begin
                    n_tidx  = AW'(r_tidx + 1'b1);
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_tidx + 1'b1);
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_count != CW'(TABLE_ENTRIES)) begin
                        wr_en      = 1'b1;
                        n_count    = CW'(r_count + 1'b1);
                        n_out_idx  = count_ext[mckt_pkg::IDX_W-1:0];
                        n_out_code = mckt_pkg::OUT_ALLOCATED;
                    end else begin
                        n_out_idx  = '0;
                        n_out_code = mckt_pkg::OUT_FULL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_slot     <= n_slot;
        r_cur_idx  <= n_cur_idx;
        r_cur_ok   <= n_cur_ok;
        r_tidx     <= n_tidx;
        r_out_idx  <= n_out_idx;
        r_out_code <= n_out_code;
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_index = r_out_idx;
    assign o_outcome     = r_out_code;

endmodule

// ===== test/lookup_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// lookup_checker : result predictor and comparator for the key table core
// Watches both channels, keeps its own copy of the table and the recent
// list, predicts entry_index and outcome for every key taken in, and checks
// results in order.
// ============================================================================
module lookup_checker #(
    parameter int TABLE_ENTRIES = 256,
    parameter int RECENT_SLOTS  = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [mckt_pkg::KEY_W-1:0]     i_format_key,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [mckt_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [mckt_pkg::CODE_W-1:0]    i_outcome,
    output int                             o_mismatch_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [mckt_pkg::IDX_W-1:0]  index;
        logic [mckt_pkg::CODE_W-1:0] code;
    } t_lookup_result;

    // Shadow copy of the descriptor table and the recent-index list
    logic [mckt_pkg::KEY_W-1:0] tbl_key  [TABLE_ENTRIES];
    logic                       tbl_used [TABLE_ENTRIES];
    logic [mckt_pkg::IDX_W-1:0] mru_idx  [RECENT_SLOTS];
    logic                       mru_used [RECENT_SLOTS];

    t_lookup_result expected_results [$];
    int             mismatches = 0;

    assign o_mismatch_count = mismatches;

    // Find the key through the recent list, then the table; else install it
    task automatic lookup_or_install(input logic [mckt_pkg::KEY_W-1:0] key,
                                     output t_lookup_result res);
        int                         s;
        int                         e;
        int                         hit_slot;
        logic [mckt_pkg::IDX_W-1:0] hit_idx;
        logic [mckt_pkg::IDX_W-1:0] old_idx;
        logic                       old_used;
        hit_slot = -1;
        for (s = 0; s < RECENT_SLOTS; s++) begin
            if (hit_slot < 0 && mru_used[s] && int'(mru_idx[s]) < TABLE_ENTRIES) begin
                if (tbl_used[mru_idx[s]] && tbl_key[mru_idx[s]] == key)
                    hit_slot = s;
            end
        end
        // recent hit: swap the slot with slot 0 (slot 0 swaps with itself)
        if (hit_slot >= 0) begin
            hit_idx            = mru_idx[hit_slot];
            mru_idx[hit_slot]  = mru_idx[0];
            mru_used[hit_slot] = mru_used[0];
            mru_idx[0]         = hit_idx;
            mru_used[0]        = 1'b1;
            res.index          = hit_idx;
            res.code           = mckt_pkg::OUT_RECENT_HIT;
            return;
        end
        // table hit: slot 0 takes the index, every other slot the old slot 0
        for (e = 0; e < TABLE_ENTRIES; e++) begin
            if (tbl_used[e] && tbl_key[e] == key) begin
                old_idx  = mru_idx[0];
                old_used = mru_used[0];
                for (s = 1; s < RECENT_SLOTS; s++) begin
                    mru_idx[s]  = old_idx;
                    mru_used[s] = old_used;
                end
                mru_idx[0]  = mckt_pkg::IDX_W'(e);
                mru_used[0] = 1'b1;
                res.index   = mckt_pkg::IDX_W'(e);
                res.code    = mckt_pkg::OUT_TABLE_HIT;
                return;
            end
        end
        // miss: first free entry, list untouched
        for (e = 0; e < TABLE_ENTRIES; e++) begin
            if (!tbl_used[e]) begin
                tbl_used[e] = 1'b1;
                tbl_key[e]  = key;
                res.index   = mckt_pkg::IDX_W'(e);
                res.code    = mckt_pkg::OUT_ALLOCATED;
                return;
            end
        end
        res.index = '0;
        res.code  = mckt_pkg::OUT_FULL;
    endtask

    // Compare results first, then queue the prediction for a new key
    always @(posedge i_clk) begin
        t_lookup_result want;
        int             delta;
        int             n;
        if (!i_rst_n) begin
            for (n = 0; n < TABLE_ENTRIES; n++) begin
                tbl_used[n] = 1'b0;
                tbl_key[n]  = '0;
            end
            for (n = 0; n < RECENT_SLOTS; n++) begin
                mru_used[n] = 1'b0;
                mru_idx[n]  = '0;
            end
            expected_results.delete();
            o_pending <= 0;
        end else begin
            delta = 0;
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no lookup pending: entry_index=%0d outcome=%0d",
                           i_entry_index, i_outcome);
                    mismatches++;
                end else begin
                    want  = expected_results.pop_front();
                    delta = delta - 1;
                    if (i_entry_index !== want.index) begin
                        $error("entry_index: expected %0d, actual %0d",
                               want.index, i_entry_index);
                        mismatches++;
                    end
                    if (i_outcome !== want.code) begin
                        $error("outcome: expected %0d, actual %0d",
                               want.code, i_outcome);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                lookup_or_install(i_format_key, want);
                expected_results.push_back(want);
                delta = delta + 1;
            end
            o_pending <= o_pending + delta;
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench : top level for the MRU-cached key table lookup core
// Drives directed and random format keys with random idling on both sides,
// one long output hold-off followed by a full drain; the checker predicts and
// compares every result.
// ============================================================================
module testbench;

    localparam int TABLE_ENTRIES    = 256;
    localparam int RECENT_SLOTS     = 5;
    localparam int LONG_HOLD_CYCLES = 2500;
    localparam int DRAIN_CYCLES     = 300;
    localparam int TIMEOUT_NS       = 6_000_000;

    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    logic [mckt_pkg::KEY_W-1:0]    i_format_key = '0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic [mckt_pkg::IDX_W-1:0]    o_entry_index;
    logic [mckt_pkg::CODE_W-1:0]   o_outcome;

    int mismatch_count;
    int pending;

    bit hold_request = 1'b0;
    bit tail_mode    = 1'b0;

    logic [mckt_pkg::KEY_W-1:0] sent_keys [$];

    // Corner keys: extremes, bit patterns, and repeats that walk the list
    logic [mckt_pkg::KEY_W-1:0] directed_keys [20] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        64'h8000_0000_0000_0001, 64'h0000_0000_0000_0001,
        64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0000_0001,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
        64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF
    };

    mru_cached_key_table_lookup_alloc_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .RECENT_SLOTS  (RECENT_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_format_key  (i_format_key),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_entry_index (o_entry_index),
        .o_outcome     (o_outcome)
    );

    lookup_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .RECENT_SLOTS  (RECENT_SLOTS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_format_key     (i_format_key),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_entry_index    (o_entry_index),
        .i_outcome        (o_outcome),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // Mix of repeats of the last few keys, repeats of any older key and
    // fresh random keys; fresh keys fill the table and then hit the full case
    function automatic logic [mckt_pkg::KEY_W-1:0] next_key();
        int pick;
        int depth;
        pick = $urandom_range(0, 99);
        if (sent_keys.size() > 0 && pick < 25) begin
            depth = (sent_keys.size() < 6) ? sent_keys.size() : 6;
            return sent_keys[sent_keys.size() - 1 - $urandom_range(0, depth - 1)];
        end
        if (sent_keys.size() > 0 && pick < 55)
            return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        return {$urandom, $urandom};
    endfunction

    // One input transaction; valid holds until accepted, then maybe a gap
    task automatic send_key(input logic [mckt_pkg::KEY_W-1:0] key, input bit may_idle);
        i_in_valid   <= 1'b1;
        i_format_key <= key;
        do @(posedge i_clk); while (!o_in_ready);
        sent_keys.push_back(key);
        if (may_idle && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (!tail_mode && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        int n;
        do @(posedge i_clk); while (!i_rst_n);

        // directed corner keys
        for (n = 0; n < 20; n++)
            send_key(directed_keys[n], 1'b1);

        // random keys, idling switched off in some windows
        for (n = 0; n < 300; n++)
            send_key(next_key(), (n / 50) % 4 != 3);

        // long output hold-off while keys keep coming, then full drain
        hold_request = 1'b1;
        for (n = 0; n < 12; n++)
            send_key(next_key(), 1'b0);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        for (n = 0; n < 420; n++)
            send_key(next_key(), (n / 40) % 3 != 2);

        // tail with no idling on either side
        tail_mode = 1'b1;
        for (n = 0; n < 100; n++)
            send_key(next_key(), 1'b0);
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
